>>> rtl/etm_pkg.sv
// ----------------------------------------------------------------------------
// Elevon and throttle mixer package
// Shared widths, fixed-point constants and register indexes of the mixer.
// ----------------------------------------------------------------------------
package etm_pkg;

    // Field widths.
    localparam int CMD_W   = 16;
    localparam int PULSE_W = 12;
    localparam int SPAN_W  = 11;
    localparam int GAIN_W  = 15;
    localparam int FLAG_W  = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Fixed-point formats: commands are Q2.14, mixed commands are Q.28.
    localparam int FRAC_CMD = 14;
    localparam int FRAC_MIX = 28;

    localparam logic signed [CMD_W-1:0] ONE_Q14     = 16'sd16384;
    localparam logic signed [CMD_W-1:0] NEG_ONE_Q14 = -16'sd16384;
    localparam logic signed [31:0]      ONE_Q28     = 32'sd268435456;
    localparam logic signed [31:0]      NEG_ONE_Q28 = -32'sd268435456;

    // Reverse flag bits.
    localparam int REV_LEFT  = 0;
    localparam int REV_RIGHT = 1;
    localparam int REV_THR   = 2;

    // Register reset values.
    localparam logic [PULSE_W-1:0] TRIM_RST     = 12'd1500;
    localparam logic [SPAN_W-1:0]  SPAN_RST     = 11'd400;
    localparam logic [GAIN_W-1:0]  GAIN_RST     = 15'd0;
    localparam logic [PULSE_W-1:0] ESC_LOW_RST  = 12'd1000;
    localparam logic [PULSE_W-1:0] ESC_HIGH_RST = 12'd2000;
    localparam logic [FLAG_W-1:0]  FLAGS_RST    = 3'd0;

    // Register indexes (word address on the configuration port).
    typedef enum logic [2:0] {
        REG_LEFT_TRIM  = 3'd0,
        REG_RIGHT_TRIM = 3'd1,
        REG_SPAN       = 3'd2,
        REG_DIFF_GAIN  = 3'd3,
        REG_ESC_LOW    = 3'd4,
        REG_ESC_HIGH   = 3'd5,
        REG_REVERSE    = 3'd6
    } t_reg_idx;

endpackage

>>> rtl/elevon_throttle_mixer_unit.sv
// ----------------------------------------------------------------------------
// Elevon and throttle mixer
// Mixes pitch and roll into left and right elevon pulse widths with aileron
// differential, and maps throttle onto the ESC pulse range.
// ----------------------------------------------------------------------------
// Output: o_valid is the valid bit of the last stage register, and the result
// word is taken at the rising edge that samples o_valid high.
// Throughput: one word per cycle; busy is never raised and the result strobe
// cannot be held off, so the six-stage pipeline never stalls.
// Reset: synchronous, active low; clears all stage valid bits and loads the
// configuration registers with their defaults.
// ----------------------------------------------------------------------------
module elevon_throttle_mixer_unit
    import etm_pkg::*;
#(
    parameter int SERVO_LOW_US  = 1000,
    parameter int SERVO_HIGH_US = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Command channel
    input  logic                     start,
    output logic                     busy,
    input  logic signed [CMD_W-1:0]  i_pitch_command,
    input  logic signed [CMD_W-1:0]  i_roll_command,
    input  logic signed [CMD_W-1:0]  i_throttle_command,
    // Result channel
    output logic                     o_valid,
    output logic [PULSE_W-1:0]       o_left_pulse_us,
    output logic [PULSE_W-1:0]       o_right_pulse_us,
    output logic [PULSE_W-1:0]       o_throttle_pulse_us,
    // Configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    localparam int LAT = 6;

    // Servo limits in units of 2^-28 us.
    localparam logic signed [42:0] SERVO_LO_Q = 43'(SERVO_LOW_US) <<< FRAC_MIX;
    localparam logic signed [42:0] SERVO_HI_Q = 43'(SERVO_HIGH_US) <<< FRAC_MIX;
    localparam logic signed [42:0] HALF_Q28   = 43'sd134217728;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PULSE_W-1:0] r_left_trim;
    logic [PULSE_W-1:0] r_right_trim;
    logic [SPAN_W-1:0]  r_span;
    logic [GAIN_W-1:0]  r_gain;
    logic [PULSE_W-1:0] r_esc_low;
    logic [PULSE_W-1:0] r_esc_high;
    logic [FLAG_W-1:0]  r_reverse;

    t_reg_idx cfg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_trim  <= TRIM_RST;
            r_right_trim <= TRIM_RST;
            r_span       <= SPAN_RST;
            r_gain       <= GAIN_RST;
            r_esc_low    <= ESC_LOW_RST;
            r_esc_high   <= ESC_HIGH_RST;
            r_reverse    <= FLAGS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LEFT_TRIM:  r_left_trim  <= pwdata[PULSE_W-1:0];
                REG_RIGHT_TRIM: r_right_trim <= pwdata[PULSE_W-1:0];
                REG_SPAN:       r_span       <= pwdata[SPAN_W-1:0];
                REG_DIFF_GAIN:  r_gain       <= pwdata[GAIN_W-1:0];
                REG_ESC_LOW:    r_esc_low    <= pwdata[PULSE_W-1:0];
                REG_ESC_HIGH:   r_esc_high   <= pwdata[PULSE_W-1:0];
                REG_REVERSE:    r_reverse    <= pwdata[FLAG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (cfg_idx)
            REG_LEFT_TRIM:  prdata = {{(DATA_W-PULSE_W){1'b0}}, r_left_trim};
            REG_RIGHT_TRIM: prdata = {{(DATA_W-PULSE_W){1'b0}}, r_right_trim};
            REG_SPAN:       prdata = {{(DATA_W-SPAN_W){1'b0}}, r_span};
            REG_DIFF_GAIN:  prdata = {{(DATA_W-GAIN_W){1'b0}}, r_gain};
            REG_ESC_LOW:    prdata = {{(DATA_W-PULSE_W){1'b0}}, r_esc_low};
            REG_ESC_HIGH:   prdata = {{(DATA_W-PULSE_W){1'b0}}, r_esc_high};
            REG_REVERSE:    prdata = {{(DATA_W-FLAG_W){1'b0}}, r_reverse};
            default:        prdata = '0;
        endcase
    end

    // The pipeline takes a word every cycle.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Valid bits travelling with the data
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: saturate the commands and take the roll magnitude
    // ------------------------------------------------------------------
    logic signed [CMD_W-1:0] n1_pitch, n1_roll, n1_thr_s;
    logic signed [CMD_W-1:0] n1_roll_neg;
    logic signed [CMD_W-1:0] r1_pitch, r1_roll;
    logic [14:0]             r1_aroll, r1_thr;

    always_comb begin
        priority if (i_pitch_command < NEG_ONE_Q14) n1_pitch = NEG_ONE_Q14;
        else if (i_pitch_command > ONE_Q14)         n1_pitch = ONE_Q14;
        else                                        n1_pitch = i_pitch_command;

        priority if (i_roll_command < NEG_ONE_Q14)  n1_roll = NEG_ONE_Q14;
        else if (i_roll_command > ONE_Q14)          n1_roll = ONE_Q14;
        else                                        n1_roll = i_roll_command;

        priority if (i_throttle_command < 16'sd0)   n1_thr_s = 16'sd0;
        else if (i_throttle_command > ONE_Q14)      n1_thr_s = ONE_Q14;
        else                                        n1_thr_s = i_throttle_command;

        n1_roll_neg = -n1_roll;
    end

    always_ff @(posedge i_clk) begin
        r1_pitch <= n1_pitch;
        r1_roll  <= n1_roll;
        r1_aroll <= n1_roll[CMD_W-1] ? n1_roll_neg[14:0] : n1_roll[14:0];
        r1_thr   <= n1_thr_s[14:0];
    end

    // ------------------------------------------------------------------
    // Stage 2: differential product, pitch/roll sums, throttle product
    // ------------------------------------------------------------------
    logic [29:0]        n2_d;
    logic [PULSE_W-1:0] n2_tlo, n2_thi;
    logic signed [12:0] n2_tspan;
    logic signed [28:0] n2_ta, n2_tb;
    logic [29:0]        r2_d;
    logic signed [16:0] r2_pmr, r2_ppr;
    logic signed [28:0] r2_tprod;
    logic [PULSE_W-1:0] r2_tlo;

    always_comb begin
        n2_d     = {15'd0, r_gain} * {15'd0, r1_aroll};
        n2_tlo   = r_reverse[REV_THR] ? r_esc_high : r_esc_low;
        n2_thi   = r_reverse[REV_THR] ? r_esc_low : r_esc_high;
        n2_tspan = signed'({1'b0, n2_thi}) - signed'({1'b0, n2_tlo});
        n2_ta    = signed'({14'd0, r1_thr});
        n2_tb    = {{16{n2_tspan[12]}}, n2_tspan};
    end

    always_ff @(posedge i_clk) begin
        r2_d     <= n2_d;
        r2_pmr   <= 17'(r1_pitch) - 17'(r1_roll);
        r2_ppr   <= 17'(r1_pitch) + 17'(r1_roll);
        r2_tprod <= n2_ta * n2_tb;
        r2_tlo   <= n2_tlo;
    end

    // ------------------------------------------------------------------
    // Stage 3: mix and saturate each side; finish the throttle pulse
    // ------------------------------------------------------------------
    logic signed [31:0] n3_lsum, n3_rsum, n3_d;
    logic signed [29:0] n3_left, n3_right;
    logic signed [29:0] n3_tus, n3_tround;
    logic signed [29:0] r3_left, r3_right;
    logic [PULSE_W-1:0] r3_thr;

    always_comb begin
        n3_d    = signed'({2'b00, r2_d});
        n3_lsum = signed'({r2_pmr[16], r2_pmr, 14'd0}) + n3_d;
        n3_rsum = signed'({r2_ppr[16], r2_ppr, 14'd0}) - n3_d;

        priority if (n3_lsum < NEG_ONE_Q28) n3_left = NEG_ONE_Q28[29:0];
        else if (n3_lsum > ONE_Q28)         n3_left = ONE_Q28[29:0];
        else                                n3_left = n3_lsum[29:0];

        priority if (n3_rsum < NEG_ONE_Q28) n3_right = NEG_ONE_Q28[29:0];
        else if (n3_rsum > ONE_Q28)         n3_right = ONE_Q28[29:0];
        else                                n3_right = n3_rsum[29:0];

        // Throttle in units of 2^-14 us, floored at zero, rounded half up.
        n3_tus = signed'({4'd0, r2_tlo, 14'd0}) + {r2_tprod[28], r2_tprod};
        if (n3_tus < 30'sd0) begin
            n3_tus = 30'sd0;
        end
        n3_tround = n3_tus + 30'sd8192;
    end

    always_ff @(posedge i_clk) begin
        r3_left  <= n3_left;
        r3_right <= n3_right;
        r3_thr   <= n3_tround[25:14];
    end

    // ------------------------------------------------------------------
    // Stage 4: scale each side by the deflection span
    // ------------------------------------------------------------------
    logic signed [41:0] n4_span;
    logic signed [41:0] r4_ldev, r4_rdev;
    logic [PULSE_W-1:0] r4_thr;

    assign n4_span = signed'({31'd0, r_span});

    always_ff @(posedge i_clk) begin
        r4_ldev <= {{12{r3_left[29]}}, r3_left} * n4_span;
        r4_rdev <= {{12{r3_right[29]}}, r3_right} * n4_span;
        r4_thr  <= r3_thr;
    end

    // ------------------------------------------------------------------
    // Stage 5: add the deviation to the trim, mirrored when reversed
    // ------------------------------------------------------------------
    logic signed [42:0] n5_ltrim, n5_rtrim, n5_ldev, n5_rdev;
    logic signed [42:0] r5_lus, r5_rus;
    logic [PULSE_W-1:0] r5_thr;

    always_comb begin
        n5_ltrim = signed'({3'd0, r_left_trim, 28'd0});
        n5_rtrim = signed'({3'd0, r_right_trim, 28'd0});
        n5_ldev  = {r4_ldev[41], r4_ldev};
        n5_rdev  = {r4_rdev[41], r4_rdev};
    end

    always_ff @(posedge i_clk) begin
        r5_lus <= r_reverse[REV_LEFT] ? n5_ltrim - n5_ldev : n5_ltrim + n5_ldev;
        r5_rus <= r_reverse[REV_RIGHT] ? n5_rtrim - n5_rdev : n5_rtrim + n5_rdev;
        r5_thr <= r4_thr;
    end

    // ------------------------------------------------------------------
    // Stage 6: servo limits (low first, then high) and rounding half up
    // ------------------------------------------------------------------
    function automatic logic [PULSE_W-1:0] servo_round(input logic signed [42:0] us);
        logic signed [42:0] v;
        v = us;
        if (v < SERVO_LO_Q) begin
            v = SERVO_LO_Q;
        end
        if (v > SERVO_HI_Q) begin
            v = SERVO_HI_Q;
        end
        if (v < 43'sd0) begin
            v = 43'sd0;
        end
        v = v + HALF_Q28;
        return v[39:28];
    endfunction

    logic [PULSE_W-1:0] r_o_left, r_o_right, r_o_thr;

    always_ff @(posedge i_clk) begin
        r_o_left  <= servo_round(r5_lus);
        r_o_right <= servo_round(r5_rus);
        r_o_thr   <= r5_thr;
    end

    assign o_valid             = r_v6;
    assign o_left_pulse_us     = r_o_left;
    assign o_right_pulse_us    = r_o_right;
    assign o_throttle_pulse_us = r_o_thr;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Every accepted word leaves the pipeline after the fixed latency.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("accepted word did not produce a result on time");

    // No result appears without a word accepted the fixed latency before.
    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result word without a matching command");

    // Elevon pulses stay inside the servo limits when these are ordered.
    a_servo_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (SERVO_LOW_US <= SERVO_HIGH_US)) |->
            (o_left_pulse_us >= 12'(SERVO_LOW_US)) &&
            (o_left_pulse_us <= 12'(SERVO_HIGH_US)) &&
            (o_right_pulse_us >= 12'(SERVO_LOW_US)) &&
            (o_right_pulse_us <= 12'(SERVO_HIGH_US)))
        else $error("elevon pulse outside the servo limits");

endmodule
